// ===== hdl/sfe_pkg.sv =====
// ----------------------------------------------------------------------------
// sfe_pkg
// shared types and constants of the stereo slice fade envelope
// ----------------------------------------------------------------------------
package sfe_pkg;

    localparam int SAMPLE_BITS_DEF      = 24;
    localparam int FRAME_COUNT_BITS_DEF = 24;
    localparam int CFG_ADDR_BITS        = 1;

    localparam logic [CFG_ADDR_BITS-1:0] REG_SLICE_FRAMES = 1'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_FADE_LEN     = 1'd1;

    typedef struct packed {
        logic last;
        logic fade;
    } sfe_flags_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } sfe_state_t;

endpackage

// ===== hdl/stereo_slice_fade_envelope_core.sv =====
// ----------------------------------------------------------------------------
// stereo_slice_fade_envelope_core
// linear fade-in and fade-out over a slice of stereo frames
// a faded frame is captured from the queue, multiplied, then divided by the
// one-bit-per-cycle divider of the scaling unit; a passed frame goes from capture
// straight to output. The scaling unit takes no new frame until the output has
// accepted the last one; a two-entry queue absorbs bursts
// reset: asynchronous active low, configuration registers and frame counter cleared, queue empty
// ----------------------------------------------------------------------------
module stereo_slice_fade_envelope_core #(
    parameter int SAMPLE_BITS      = sfe_pkg::SAMPLE_BITS_DEF,
    parameter int FRAME_COUNT_BITS = sfe_pkg::FRAME_COUNT_BITS_DEF,
    localparam int DATA_BITS       = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [sfe_pkg::CFG_ADDR_BITS-1:0] cfg_addr,
    input  logic [FRAME_COUNT_BITS-1:0]       cfg_wdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [DATA_BITS-1:0]              s_tdata,  // left_in, right_in
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [DATA_BITS-1:0]              m_tdata,  // left_out, right_out
    output logic                              m_tlast
);
    import sfe_pkg::*;

    localparam int S = SAMPLE_BITS;
    localparam int F = FRAME_COUNT_BITS;
    localparam int W = 2 * S + 2 * F + 2;

    logic         push;
    logic         full;
    logic [S-1:0] f_left;
    logic [S-1:0] f_right;
    logic [F-1:0] f_num;
    logic [F-1:0] f_den;
    sfe_flags_t   f_flags;
    logic [W-1:0] wr_data;
    logic [W-1:0] rd_data;
    logic         q_valid;
    logic         q_pop;
    sfe_flags_t   b_flags;
    logic [S-1:0] left_out;
    logic [S-1:0] right_out;

    sfe_front #(
        .SAMPLE_BITS      (S),
        .FRAME_COUNT_BITS (F)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .left_in   (s_tdata[S-1:0]),
        .right_in  (s_tdata[2*S-1:S]),
        .push      (push),
        .full      (full),
        .left_raw  (f_left),
        .right_raw (f_right),
        .num       (f_num),
        .den       (f_den),
        .flags     (f_flags)
    );

    assign wr_data = {f_flags, f_den, f_num, f_right, f_left};

    sfe_fifo #(
        .WIDTH (W)
    ) u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .wr_data   (wr_data),
        .full      (full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .rd_data   (rd_data)
    );

    assign b_flags = rd_data[W-1:W-2];

    sfe_back #(
        .SAMPLE_BITS      (S),
        .FRAME_COUNT_BITS (F)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (q_valid),
        .pop       (q_pop),
        .left_raw  (rd_data[S-1:0]),
        .right_raw (rd_data[2*S-1:S]),
        .num       (rd_data[2*S+F-1:2*S]),
        .den       (rd_data[2*S+2*F-1:2*S+F]),
        .flags     (b_flags),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .left_out  (left_out),
        .right_out (right_out),
        .slice_end (m_tlast)
    );

    assign m_tdata = DATA_BITS'({right_out, left_out});

endmodule

// ===== hdl/sfe_front.sv =====
// ----------------------------------------------------------------------------
// sfe_front
// frame counter and fade classification of each accepted frame
// ----------------------------------------------------------------------------
module sfe_front #(
    parameter int SAMPLE_BITS      = sfe_pkg::SAMPLE_BITS_DEF,
    parameter int FRAME_COUNT_BITS = sfe_pkg::FRAME_COUNT_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [sfe_pkg::CFG_ADDR_BITS-1:0]  cfg_addr,
    input  logic [FRAME_COUNT_BITS-1:0]        cfg_wdata,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  logic [SAMPLE_BITS-1:0]             left_in,
    input  logic [SAMPLE_BITS-1:0]             right_in,
    output logic                               push,
    input  logic                               full,
    output logic [SAMPLE_BITS-1:0]             left_raw,
    output logic [SAMPLE_BITS-1:0]             right_raw,
    output logic [FRAME_COUNT_BITS-1:0]        num,
    output logic [FRAME_COUNT_BITS-1:0]        den,
    output sfe_pkg::sfe_flags_t                flags
);
    import sfe_pkg::*;

    localparam int F = FRAME_COUNT_BITS;

    logic [F-1:0] slice_frames_reg;
    logic [F-1:0] fade_len_reg;
    logic [F-1:0] frame_index_reg;
    logic [F-1:0] frame_index_next;

    logic [F-1:0] half;
    logic [F-1:0] n;
    logic         active;
    logic         in_head;
    logic         in_tail;
    logic         last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slice_frames_reg <= '0;
            fade_len_reg     <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_SLICE_FRAMES: slice_frames_reg <= cfg_wdata;
                REG_FADE_LEN:     fade_len_reg     <= cfg_wdata;
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        half    = slice_frames_reg >> 1;
        n       = (fade_len_reg > half) ? half : fade_len_reg;
        active  = (fade_len_reg != '0) && (slice_frames_reg >= F'(2))
                  && (frame_index_reg < slice_frames_reg);
        in_head = frame_index_reg < n;
        in_tail = frame_index_reg >= (slice_frames_reg - n);
        last    = (slice_frames_reg == '0)
                  || (frame_index_reg >= (slice_frames_reg - F'(1)));
        frame_index_next = last ? '0 : (frame_index_reg + F'(1));
    end

    assign in_ready   = !full;
    assign push       = in_valid && !full;
    assign left_raw   = left_in;
    assign right_raw  = right_in;
    assign num        = in_head ? frame_index_reg : (slice_frames_reg - frame_index_reg);
    assign den        = n;
    assign flags.last = last;
    assign flags.fade = active && (in_head || in_tail);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            frame_index_reg <= '0;
        else if (push)
            frame_index_reg <= frame_index_next;
    end

endmodule

// ===== hdl/sfe_fifo.sv =====
// ----------------------------------------------------------------------------
// sfe_fifo
// two-entry queue between classification and the scaling unit
// ----------------------------------------------------------------------------
module sfe_fifo #(
    parameter int WIDTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             pop,
    output logic             not_empty,
    output logic [WIDTH-1:0] rd_data
);
    import sfe_pkg::*;

    logic [WIDTH-1:0] mem [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       count_reg;
    logic             do_pop;

    assign full      = count_reg == 2'd2;
    assign not_empty = count_reg != 2'd0;
    assign do_pop    = pop && not_empty;
    assign rd_data   = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= wr_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= !wr_ptr_reg;
            if (do_pop)
                rd_ptr_reg <= !rd_ptr_reg;
            case ({push, do_pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

// ===== hdl/sfe_back.sv =====
// ----------------------------------------------------------------------------
// sfe_back
// gain scaling: magnitude times numerator, bit-serial divide by the capped fade length
// ----------------------------------------------------------------------------
module sfe_back #(
    parameter int SAMPLE_BITS      = sfe_pkg::SAMPLE_BITS_DEF,
    parameter int FRAME_COUNT_BITS = sfe_pkg::FRAME_COUNT_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        pop,
    input  logic [SAMPLE_BITS-1:0]      left_raw,
    input  logic [SAMPLE_BITS-1:0]      right_raw,
    input  logic [FRAME_COUNT_BITS-1:0] num,
    input  logic [FRAME_COUNT_BITS-1:0] den,
    input  sfe_pkg::sfe_flags_t         flags,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [SAMPLE_BITS-1:0]      left_out,
    output logic [SAMPLE_BITS-1:0]      right_out,
    output logic                        slice_end
);
    import sfe_pkg::*;

    localparam int S  = SAMPLE_BITS;
    localparam int F  = FRAME_COUNT_BITS;
    localparam int P  = S + F;
    localparam int CW = $clog2(S);

    sfe_state_t state_reg;
    sfe_state_t state_next;

    logic [S-1:0]  left_raw_reg;
    logic [S-1:0]  right_raw_reg;
    logic [F-1:0]  num_reg;
    logic [F-1:0]  den_reg;
    sfe_flags_t    flags_reg;
    logic [F-1:0]  rem_l_reg;
    logic [F-1:0]  rem_r_reg;
    logic [S-1:0]  lo_l_reg;
    logic [S-1:0]  lo_r_reg;
    logic [CW-1:0] cnt_reg;

    logic [S-1:0]  mag_l;
    logic [S-1:0]  mag_r;
    logic [P-1:0]  prod_l;
    logic [P-1:0]  prod_r;
    logic [F:0]    trial_l;
    logic [F:0]    trial_r;
    logic          ge_l;
    logic          ge_r;
    logic [F:0]    diff_l;
    logic [F:0]    diff_r;
    logic          div_done;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (in_valid)
                    state_next = flags.fade ? ST_MUL : ST_DONE;
            ST_MUL:
                state_next = ST_DIV;
            ST_DIV:
                if (div_done)
                    state_next = ST_DONE;
            ST_DONE:
                if (out_ready)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        pop       = 1'b0;
        out_valid = 1'b0;
        unique case (state_reg)
            ST_IDLE: pop       = 1'b1;
            ST_DONE: out_valid = 1'b1;
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // magnitude of the most negative sample still fits as unsigned
    always_comb
    begin
        mag_l    = left_raw_reg[S-1]  ? (S'(0) - left_raw_reg)  : left_raw_reg;
        mag_r    = right_raw_reg[S-1] ? (S'(0) - right_raw_reg) : right_raw_reg;
        prod_l   = P'(mag_l) * P'(num_reg);
        prod_r   = P'(mag_r) * P'(num_reg);
        trial_l  = {rem_l_reg, lo_l_reg[S-1]};
        trial_r  = {rem_r_reg, lo_r_reg[S-1]};
        ge_l     = trial_l >= {1'b0, den_reg};
        ge_r     = trial_r >= {1'b0, den_reg};
        diff_l   = ge_l ? (trial_l - {1'b0, den_reg}) : trial_l;
        diff_r   = ge_r ? (trial_r - {1'b0, den_reg}) : trial_r;
        div_done = cnt_reg == CW'(S - 1);
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    left_raw_reg  <= left_raw;
                    right_raw_reg <= right_raw;
                    num_reg       <= num;
                    den_reg       <= den;
                    flags_reg     <= flags;
                end
            end
            ST_MUL:
            begin
                // quotient never exceeds the magnitude, so the high part starts below den
                rem_l_reg <= prod_l[P-1:S];
                rem_r_reg <= prod_r[P-1:S];
                lo_l_reg  <= prod_l[S-1:0];
                lo_r_reg  <= prod_r[S-1:0];
                cnt_reg   <= '0;
            end
            ST_DIV:
            begin
                rem_l_reg <= diff_l[F-1:0];
                rem_r_reg <= diff_r[F-1:0];
                lo_l_reg  <= {lo_l_reg[S-2:0], ge_l};
                lo_r_reg  <= {lo_r_reg[S-2:0], ge_r};
                cnt_reg   <= cnt_reg + CW'(1);
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        if (flags_reg.fade)
        begin
            left_out  = left_raw_reg[S-1]  ? (S'(0) - lo_l_reg) : lo_l_reg;
            right_out = right_raw_reg[S-1] ? (S'(0) - lo_r_reg) : lo_r_reg;
        end
        else
        begin
            left_out  = left_raw_reg;
            right_out = right_raw_reg;
        end
    end

    assign slice_end = flags_reg.last;

endmodule
